// File: hw/rtl/i2c_master_byte_sequencer_assert.svh
// Assertion macros shared by the sequencer modules.
`ifndef I2C_MASTER_BYTE_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BYTE_SEQUENCER_ASSERT_SVH

// Clocked check, held off while reset is high.
`define SEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define SEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer package
// Codes, command and status types shared by controller, datapath and top.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int BYTE_W            = 8;
  localparam int BITS_PER_BYTE_DEF = 8;
  localparam int CFG_ADDR_W        = 2;

  typedef enum logic [2:0] {
    REQ_START     = 3'd0,
    REQ_STOP      = 3'd1,
    REQ_WRITE     = 3'd2,
    REQ_READ_ACK  = 3'd3,
    REQ_READ_NACK = 3'd4,
    REQ_SAMPLE    = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    K_PIN_WRITE  = 3'd0,
    K_SAMPLE_REQ = 3'd1,
    K_DONE       = 3'd2,
    K_BYTE       = 3'd3,
    K_NACK       = 3'd4
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SDA_MASK  = 2'd0,
    REG_SCL_MASK  = 2'd1,
    REG_CTRL_MASK = 2'd2
  } cfg_reg_t;

  // Pin word selection for a pin write
  typedef enum logic [3:0] {
    PS_ZERO,
    PS_ALL,
    PS_SCL_CTRL,
    PS_SCL,
    PS_CTRL,
    PS_SDA_CTRL,
    PS_CTRL_PREV,
    PS_CTRL_DBIT,
    PS_CTRL_SCL_DBIT,
    PS_PREV,
    PS_SAMPLE_SDA
  } psel_t;

  // Datapath register actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_WR_INIT,
    ACT_WR_SHIFT,
    ACT_RD_INIT_ACK,
    ACT_RD_INIT_NACK,
    ACT_CAPTURE,
    ACT_RD_BIT,
    ACT_NACK_SET,
    ACT_STOP_END
  } act_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WAIT_STOP,
    ST_WAIT_ACK,
    ST_WAIT_READ,
    ST_START_ALL,
    ST_START_SC,
    ST_DONE,
    ST_STOP_REQ,
    ST_WR_PREV,
    ST_WR_DBIT,
    ST_WR_CLK,
    ST_WR_LAST,
    ST_WR_SCL,
    ST_WR_REQ,
    ST_STP_A,
    ST_STP_B,
    ST_STP_END,
    ST_ACK_ZERO,
    ST_RD_SCL,
    ST_RD_REQ,
    ST_RD_BIT,
    ST_RA_CTRL,
    ST_RA_SC,
    ST_RN_CTRL,
    ST_RN_SDAC,
    ST_RN_ALL,
    ST_RD_ZERO,
    ST_RD_BYTE
  } state_t;

  typedef struct packed {
    logic  go;     // load the output register this cycle
    kind_t kind;
    psel_t psel;
    logic  last;
    act_t  act;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic stop_needed;
    logic sda_high;
    logic wr_last;
    logic rd_last;
    logic pend_nack;
    logic after_nack;
  } sts_t;

endpackage

// File: hw/rtl/i2cms_datapath.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer datapath
// Mask registers, bit shifters, sample capture and the output register.
// ----------------------------------------------------------------------------
module i2cms_datapath
  import i2cms_pkg::*;
#(
  parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BYTE_W-1:0]     cfg_wdata,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic [BYTE_W-1:0]     pin_sample,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic [2:0]            out_kind,
  output logic [BYTE_W-1:0]     pin_word,
  output logic [BYTE_W-1:0]     read_byte,
  output logic                  last
);

  localparam int CNT_W = $clog2(BITS_PER_BYTE + 1);
  localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(BITS_PER_BYTE);
  localparam logic [CNT_W-1:0] CNT_WR_LAST = CNT_W'(BITS_PER_BYTE - 1);
  localparam logic [CNT_W-1:0] CNT_ONE     = CNT_W'(1);

  logic [BYTE_W-1:0] sda_mask, scl_mask, ctrl_mask;
  logic [BYTE_W-1:0] all_mask;
  logic [BYTE_W-1:0] data_sh;
  logic [BYTE_W-1:0] shift_byte;
  logic [BYTE_W-1:0] sample;
  logic [CNT_W-1:0]  cnt;
  logic              prev_bit;
  logic              pend_nack;
  logic              after_nack;
  logic              dbit;
  logic [BYTE_W-1:0] dbit_word;
  logic [BYTE_W-1:0] prev_word;
  logic [BYTE_W-1:0] samp_sda;
  logic [BYTE_W-1:0] pin_sel;

  assign all_mask  = sda_mask | scl_mask | ctrl_mask;
  assign dbit      = data_sh[BYTE_W-1];
  assign dbit_word = dbit ? sda_mask : '0;
  assign prev_word = prev_bit ? sda_mask : '0;
  assign samp_sda  = sample & sda_mask;

  always_comb begin
    unique case (cmd.psel)
      PS_ZERO:          pin_sel = '0;
      PS_ALL:           pin_sel = all_mask;
      PS_SCL_CTRL:      pin_sel = scl_mask | ctrl_mask;
      PS_SCL:           pin_sel = scl_mask;
      PS_CTRL:          pin_sel = ctrl_mask;
      PS_SDA_CTRL:      pin_sel = sda_mask | ctrl_mask;
      PS_CTRL_PREV:     pin_sel = ctrl_mask | prev_word;
      PS_CTRL_DBIT:     pin_sel = ctrl_mask | dbit_word;
      PS_CTRL_SCL_DBIT: pin_sel = ctrl_mask | scl_mask | dbit_word;
      PS_PREV:          pin_sel = prev_word;
      PS_SAMPLE_SDA:    pin_sel = samp_sda;
      default:          pin_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sda_mask  <= BYTE_W'(1);
      scl_mask  <= BYTE_W'(2);
      ctrl_mask <= BYTE_W'(4);
    end else if (cfg_we) begin
      if (cfg_addr == REG_SDA_MASK)  sda_mask  <= cfg_wdata;
      if (cfg_addr == REG_SCL_MASK)  scl_mask  <= cfg_wdata;
      if (cfg_addr == REG_CTRL_MASK) ctrl_mask <= cfg_wdata;
    end
  end

  // Control state of the bit sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      prev_bit   <= 1'b0;
      pend_nack  <= 1'b0;
      after_nack <= 1'b0;
    end else begin
      unique case (cmd.act)
        ACT_WR_INIT: begin
          cnt      <= '0;
          prev_bit <= 1'b0;
        end
        ACT_WR_SHIFT: begin
          cnt      <= cnt + CNT_ONE;
          prev_bit <= dbit;
        end
        ACT_RD_INIT_ACK: begin
          cnt       <= CNT_FULL;
          pend_nack <= 1'b0;
        end
        ACT_RD_INIT_NACK: begin
          cnt       <= CNT_FULL;
          pend_nack <= 1'b1;
        end
        ACT_RD_BIT:   if (cnt != '0) cnt <= cnt - CNT_ONE;
        ACT_NACK_SET: after_nack <= 1'b1;
        ACT_STOP_END: after_nack <= 1'b0;
        default: ;
      endcase
    end
  end

  // Payload shifters
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      ACT_WR_INIT:      data_sh <= data_byte;
      ACT_WR_SHIFT:     data_sh <= {data_sh[BYTE_W-2:0], 1'b0};
      ACT_RD_INIT_ACK,
      ACT_RD_INIT_NACK: shift_byte <= '0;
      ACT_CAPTURE:      sample <= pin_sample;
      ACT_RD_BIT:       shift_byte <= {shift_byte[BYTE_W-2:0], (samp_sda != '0)};
      default: ;
    endcase
  end

  // Output register: loads while empty or while the present transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.go) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      out_kind  <= cmd.kind;
      pin_word  <= (cmd.kind == K_PIN_WRITE) ? pin_sel : '0;
      read_byte <= (cmd.kind == K_BYTE) ? shift_byte : '0;
      last      <= cmd.last;
    end
  end

  assign sts.out_free    = !m_valid || m_ready;
  assign sts.stop_needed = (sample & all_mask) != all_mask;
  assign sts.sda_high    = samp_sda != '0;
  assign sts.wr_last     = cnt == CNT_WR_LAST;
  assign sts.rd_last     = cnt == CNT_ONE;
  assign sts.pend_nack   = pend_nack;
  assign sts.after_nack  = after_nack;

`include "i2c_master_byte_sequencer_assert.svh"

  `SEQ_ASSERT(a_cnt_range, cnt <= CNT_FULL, "bit counter beyond byte length")
  `SEQ_ASSERT(a_byte_only_kind, m_valid && out_kind != K_BYTE |-> read_byte == '0, "read byte on non-byte result")
  `SEQ_ASSERT(a_pin_only_write, m_valid && out_kind != K_PIN_WRITE |-> pin_word == '0, "pin word on non-write result")

endmodule

// File: hw/rtl/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer controller
// Walks the pin-write sequence of each command, one result per cycle while the output register has room.
// ----------------------------------------------------------------------------
module i2cms_ctrl
  import i2cms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [2:0] req_type,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   emit;
  state_t emit_next;
  act_t   emit_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_ready    = 1'b0;
    emit       = 1'b0;
    emit_next  = state;
    emit_act   = ACT_NONE;
    cmd.go     = 1'b0;
    cmd.kind   = K_PIN_WRITE;
    cmd.psel   = PS_ZERO;
    cmd.last   = 1'b0;
    cmd.act    = ACT_NONE;

    unique case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          unique case (req_type)
            REQ_START:     state_next = ST_START_ALL;
            REQ_STOP:      state_next = ST_STOP_REQ;
            REQ_WRITE: begin
              cmd.act    = ACT_WR_INIT;
              state_next = ST_WR_PREV;
            end
            REQ_READ_ACK: begin
              cmd.act    = ACT_RD_INIT_ACK;
              state_next = ST_RD_SCL;
            end
            REQ_READ_NACK: begin
              cmd.act    = ACT_RD_INIT_NACK;
              state_next = ST_RD_SCL;
            end
            default: ;  // samples and unknown codes drop here
          endcase
        end
      end
      ST_WAIT_STOP, ST_WAIT_ACK, ST_WAIT_READ: begin
        s_ready = 1'b1;
        if (s_valid && req_type == REQ_SAMPLE) begin
          cmd.act = ACT_CAPTURE;
          priority case (state)
            ST_WAIT_STOP: state_next = ST_STP_A;
            ST_WAIT_ACK:  state_next = ST_ACK_ZERO;
            default:      state_next = ST_RD_BIT;
          endcase
        end
      end
      ST_START_ALL: begin
        emit = 1'b1; cmd.psel = PS_ALL; emit_next = ST_START_SC;
      end
      ST_START_SC: begin
        emit = 1'b1; cmd.psel = PS_SCL_CTRL; emit_next = ST_DONE;
      end
      ST_DONE: begin
        emit = 1'b1; cmd.kind = K_DONE; cmd.last = 1'b1; emit_next = ST_IDLE;
      end
      ST_STOP_REQ: begin
        emit = 1'b1; cmd.kind = K_SAMPLE_REQ; cmd.last = 1'b1; emit_next = ST_WAIT_STOP;
      end
      ST_WR_PREV: begin
        emit = 1'b1; cmd.psel = PS_CTRL_PREV; emit_next = ST_WR_DBIT;
      end
      ST_WR_DBIT: begin
        emit = 1'b1; cmd.psel = PS_CTRL_DBIT; emit_next = ST_WR_CLK;
      end
      ST_WR_CLK: begin
        emit      = 1'b1;
        cmd.psel  = PS_CTRL_SCL_DBIT;
        emit_act  = ACT_WR_SHIFT;
        emit_next = sts.wr_last ? ST_WR_LAST : ST_WR_PREV;
      end
      ST_WR_LAST: begin
        emit = 1'b1; cmd.psel = PS_PREV; emit_next = ST_WR_SCL;
      end
      ST_WR_SCL: begin
        emit = 1'b1; cmd.psel = PS_SCL; emit_next = ST_WR_REQ;
      end
      ST_WR_REQ: begin
        emit = 1'b1; cmd.kind = K_SAMPLE_REQ; cmd.last = 1'b1; emit_next = ST_WAIT_ACK;
      end
      ST_STP_A: begin
        emit = 1'b1;
        if (sts.stop_needed) begin
          cmd.psel  = PS_SCL_CTRL;
          emit_next = ST_STP_B;
        end else begin
          // pins already released: finish straight away
          cmd.kind  = sts.after_nack ? K_NACK : K_DONE;
          cmd.last  = 1'b1;
          emit_act  = ACT_STOP_END;
          emit_next = ST_IDLE;
        end
      end
      ST_STP_B: begin
        emit = 1'b1; cmd.psel = PS_ALL; emit_next = ST_STP_END;
      end
      ST_STP_END: begin
        emit      = 1'b1;
        cmd.kind  = sts.after_nack ? K_NACK : K_DONE;
        cmd.last  = 1'b1;
        emit_act  = ACT_STOP_END;
        emit_next = ST_IDLE;
      end
      ST_ACK_ZERO: begin
        emit     = 1'b1;
        cmd.psel = PS_ZERO;
        if (sts.sda_high) begin
          // no ack from the target: release the bus and report
          emit_act  = ACT_NACK_SET;
          emit_next = ST_STOP_REQ;
        end else begin
          emit_next = ST_DONE;
        end
      end
      ST_RD_SCL: begin
        emit = 1'b1; cmd.psel = PS_SCL; emit_next = ST_RD_REQ;
      end
      ST_RD_REQ: begin
        emit = 1'b1; cmd.kind = K_SAMPLE_REQ; cmd.last = 1'b1; emit_next = ST_WAIT_READ;
      end
      ST_RD_BIT: begin
        emit     = 1'b1;
        cmd.psel = PS_SAMPLE_SDA;
        emit_act = ACT_RD_BIT;
        if (!sts.rd_last) begin
          emit_next = ST_RD_SCL;
        end else if (sts.pend_nack) begin
          emit_next = ST_RN_CTRL;
        end else begin
          emit_next = ST_RA_CTRL;
        end
      end
      ST_RA_CTRL: begin
        emit = 1'b1; cmd.psel = PS_CTRL; emit_next = ST_RA_SC;
      end
      ST_RA_SC: begin
        emit = 1'b1; cmd.psel = PS_SCL_CTRL; emit_next = ST_RD_ZERO;
      end
      ST_RN_CTRL: begin
        emit = 1'b1; cmd.psel = PS_CTRL; emit_next = ST_RN_SDAC;
      end
      ST_RN_SDAC: begin
        emit = 1'b1; cmd.psel = PS_SDA_CTRL; emit_next = ST_RN_ALL;
      end
      ST_RN_ALL: begin
        emit = 1'b1; cmd.psel = PS_ALL; emit_next = ST_RD_ZERO;
      end
      ST_RD_ZERO: begin
        emit = 1'b1; cmd.psel = PS_ZERO; emit_next = ST_RD_BYTE;
      end
      ST_RD_BYTE: begin
        emit = 1'b1; cmd.kind = K_BYTE; cmd.last = 1'b1; emit_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // Advance only when the output register can take the result
    if (emit && sts.out_free) begin
      cmd.go     = 1'b1;
      cmd.act    = emit_act;
      state_next = emit_next;
    end
  end

`include "i2c_master_byte_sequencer_assert.svh"

  `SEQ_ASSERT(a_no_emit_when_listening, !(s_ready && cmd.go), "result emitted while taking input")
  `SEQ_ASSERT(a_go_needs_room, cmd.go |-> sts.out_free, "output register overrun")
  `SEQ_ASSERT(a_last_returns_to_listen, cmd.go && cmd.last |=> s_ready, "no listen state after last result")

endmodule

// File: hw/rtl/i2c_master_byte_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer
// Turns start, stop, write and read commands into bit-banged pin-word writes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands and pin samples (tuser = request type). m_axis
//   carries results (tuser = result kind); tlast marks the final result of
//   the input item that caused it. Each pin-sample request on m_axis must be
//   answered by a sample item on s_axis before the next command is taken.
//   Masks are written through cfg_we/cfg_addr/cfg_wdata while the block idles.
// Timing:
//   An accepted item selects its first result state, which then loads that
//   result into the output register; further results follow one per cycle
//   while m_axis has room, so a write command gives 27 results, a start 3.
//   A sample accepted while a result is awaited decodes in the same way.
//   The controller walks one result per cycle while the output register has room; that sets the throughput.
// Reset:
//   rst clears the state machine and the output valid, and reloads the masks
//   with SDA=1, SCL=2, CTRL=4.
// Stall:
//   While m_axis_tready is low the current result holds and the sequence
//   pauses; s_axis_tready stays low until the last result has been loaded.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer
  import i2cms_pkg::*;
#(
  parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BYTE_W-1:0]     cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // data_byte [7:0], pin_sample [15:8]
  input  logic [2:0]            s_axis_tuser,   // req_type [2:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // pin_word [7:0], read_byte [15:8]
  output logic [2:0]            m_axis_tuser,   // out_kind [2:0]
  output logic                  m_axis_tlast
);

  cmd_t              cmd;
  sts_t              sts;
  logic [BYTE_W-1:0] pin_word;
  logic [BYTE_W-1:0] read_byte;

  i2cms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .req_type (s_axis_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2cms_datapath #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .data_byte  (s_axis_tdata[7:0]),
    .pin_sample (s_axis_tdata[15:8]),
    .cmd        (cmd),
    .sts        (sts),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .pin_word   (pin_word),
    .read_byte  (read_byte),
    .last       (m_axis_tlast)
  );

  assign m_axis_tdata = {read_byte, pin_word};

endmodule
